// File: rtl/core/tksht_pkg.sv
package tksht_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int TIME_W        = 63;
  localparam int VALUE_W       = 64;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int FILL_W        = 7;
  localparam int INDEX_W       = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT      = 2'd0,
    OP_KEEP_NEWEST = 2'd1,
    OP_KEEP_RANGE  = 2'd2,
    OP_READ        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_REPLACED = 2'd1,
    STATUS_DROPPED  = 2'd2,
    STATUS_DONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REPLACE,
    CELL_SHIFT_DOWN
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [TIME_W-1:0]   key_time;
    logic [TIME_W-1:0]   range_end;
    logic [VALUE_W-1:0]  key_value;
  } cell_ctrl_t;

  typedef struct packed {
    logic below_key;
    logic match_key;
    logic within_end;
  } cell_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

// File: rtl/core/tksht_cell.sv
module tksht_cell
  import tksht_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               occupied,
  input  logic               left_below,
  input  logic [TIME_W-1:0]  left_time,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [TIME_W-1:0]  right_time,
  input  logic [VALUE_W-1:0] right_value,
  output logic [TIME_W-1:0]  slot_time,
  output logic [VALUE_W-1:0] slot_value,
  output cell_flags_t        flags
);

  logic [TIME_W-1:0]  slot_time_next;
  logic [VALUE_W-1:0] slot_value_next;

  always_comb begin
    slot_time_next  = slot_time;
    slot_value_next = slot_value;
    unique case (ctrl.cmd)
      CELL_INSERT: begin
        // cells below the new time stay, the boundary cell takes the key,
        // everything above moves up one place
        if (!flags.below_key) begin
          if (left_below) begin
            slot_time_next  = ctrl.key_time;
            slot_value_next = ctrl.key_value;
          end else begin
            slot_time_next  = left_time;
            slot_value_next = left_value;
          end
        end
      end
      CELL_REPLACE: begin
        if (flags.match_key) begin
          slot_value_next = ctrl.key_value;
        end
      end
      CELL_SHIFT_DOWN: begin
        slot_time_next  = right_time;
        slot_value_next = right_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_time        <= slot_time_next;
    slot_value       <= slot_value_next;
    flags.below_key  <= occupied && (slot_time < ctrl.key_time);
    flags.match_key  <= occupied && (slot_time == ctrl.key_time);
    flags.within_end <= occupied && (slot_time <= ctrl.range_end);
  end

endmodule

// File: rtl/core/time_keyed_sorted_history_table.sv
// Sorted table of (time, value) points, oldest time at position zero.
// Request channel: req_valid / req_stall with op, key_time, key_value,
// keep_count, range_end and read_index. Response channel: rsp_valid /
// rsp_stall with status, fill_level, entry_valid, entry_time, entry_value.
// Every request item produces exactly one response item.
// The table is a chain of cells; each cell compares its own time against
// the key and exchanges data only with its two neighbors.
// Insert, replace and read pass from accept through the eval, apply and
// finish states. Keep newest and keep range drop old points by shifting
// the chain down one place per cycle in a shift state between apply and
// finish, once per oldest point dropped. A new request is taken once the
// previous item has reached the response register.
// Reset empties the table at once (fill level zero); no clearing pass.
// A stalled response holds in the output register; the block may take the
// next request meanwhile but will not finish it until the register frees.
module time_keyed_sorted_history_table
  import tksht_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [OP_W-1:0]           op,
  input  logic [TIME_W-1:0]         key_time,
  input  logic signed [VALUE_W-1:0] key_value,
  input  logic [FILL_W-1:0]         keep_count,
  input  logic [TIME_W-1:0]         range_end,
  input  logic [INDEX_W-1:0]        read_index,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [FILL_W-1:0]         fill_level,
  output logic                      entry_valid,
  output logic [TIME_W-1:0]         entry_time,
  output logic signed [VALUE_W-1:0] entry_value
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  state_t state, state_next;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [CNT_W-1:0]   shift_left_cnt;
  logic [CNT_W-1:0]   drop_count;

  op_t                op_q;
  logic [TIME_W-1:0]  key_time_q;
  logic [VALUE_W-1:0] key_value_q;
  logic [FILL_W-1:0]  keep_q;
  logic [TIME_W-1:0]  range_end_q;
  logic [INDEX_W-1:0] read_index_q;

  status_t            res_status;
  status_t            res_status_next;
  logic               res_valid;
  logic [TIME_W-1:0]  res_time;
  logic [VALUE_W-1:0] res_value;

  cell_cmd_t          cell_cmd;
  cell_ctrl_t         ctrl;
  logic               accept;
  logic               rsp_load;
  logic               any_match;
  logic               full;

  logic [TIME_W-1:0]      cell_time  [TABLE_DEPTH];
  logic [VALUE_W-1:0]     cell_value [TABLE_DEPTH];
  cell_flags_t            cell_flags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ;
  logic [TABLE_DEPTH:0]   below_ext;
  logic [TABLE_DEPTH:0]   within_ext;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [CNT_W-1:0]       pos_first;
  logic [CNT_W-1:0]       pos_last;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       keep_ext;
  logic [TIME_W-1:0]      rd_time;
  logic [VALUE_W-1:0]     rd_value;
  logic                   rd_hit;

  assign accept = req_valid && !req_stall;

  assign ctrl.cmd       = cell_cmd;
  assign ctrl.key_time  = key_time_q;
  assign ctrl.range_end = range_end_q;
  assign ctrl.key_value = key_value_q;

  // chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic               left_below;
    logic [TIME_W-1:0]  left_time;
    logic [VALUE_W-1:0] left_value;
    logic [TIME_W-1:0]  right_time;
    logic [VALUE_W-1:0] right_value;

    assign occ[i] = (CNT_W'(i) < cnt);

    if (i == 0) begin : g_first
      assign left_below = 1'b1;
      assign left_time  = '0;
      assign left_value = '0;
    end else begin : g_mid
      assign left_below = cell_flags[i-1].below_key;
      assign left_time  = cell_time[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_time  = '0;
      assign right_value = '0;
    end else begin : g_inner
      assign right_time  = cell_time[i+1];
      assign right_value = cell_value[i+1];
    end

    tksht_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[i]),
      .left_below  (left_below),
      .left_time   (left_time),
      .left_value  (left_value),
      .right_time  (right_time),
      .right_value (right_value),
      .slot_time   (cell_time[i]),
      .slot_value  (cell_value[i]),
      .flags       (cell_flags[i])
    );

    assign below_ext[i]  = cell_flags[i].below_key;
    assign within_ext[i] = cell_flags[i].within_end;
    assign match_vec[i]  = cell_flags[i].match_key;
  end

  assign below_ext[TABLE_DEPTH]  = 1'b0;
  assign within_ext[TABLE_DEPTH] = 1'b0;

  assign any_match = |match_vec;
  assign full      = (cnt == CNT_W'(TABLE_DEPTH));
  assign cnt_ext   = CMP_W'(cnt);
  assign keep_ext  = CMP_W'(keep_q);

  // flags are thermometer codes over the sorted table: encode the boundary
  always_comb begin
    pos_first = '0;
    pos_last  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (below_ext[i] && !below_ext[i+1]) begin
        pos_first = pos_first | CNT_W'(i + 1);
      end
      if (within_ext[i] && !within_ext[i+1]) begin
        pos_last = pos_last | CNT_W'(i + 1);
      end
    end
  end

  // read port, and-or over the cells
  always_comb begin
    rd_time  = '0;
    rd_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == int'(read_index_q)) begin
        rd_time  = rd_time | cell_time[i];
        rd_value = rd_value | cell_value[i];
      end
    end
  end

  assign rd_hit = (CMP_W'(read_index_q) < cnt_ext);

  // next fill level, drop count and result code of the apply step
  always_comb begin
    cnt_next        = cnt;
    drop_count      = '0;
    res_status_next = STATUS_DONE;
    unique case (op_q)
      OP_INSERT: begin
        if (any_match) begin
          res_status_next = STATUS_REPLACED;
        end else if (full) begin
          res_status_next = STATUS_DROPPED;
        end else begin
          res_status_next = STATUS_INSERTED;
          cnt_next        = cnt + CNT_W'(1);
        end
      end
      OP_KEEP_NEWEST: begin
        if (keep_ext < cnt_ext) begin
          cnt_next   = CNT_W'(keep_q);
          drop_count = CNT_W'(cnt_ext - keep_ext);
        end
      end
      OP_KEEP_RANGE: begin
        if (key_time_q > range_end_q) begin
          cnt_next = '0;
        end else begin
          cnt_next   = pos_last - pos_first;
          drop_count = pos_first;
        end
      end
      OP_READ: begin
      end
      default: begin
      end
    endcase
  end

  // state machine: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (drop_count != '0) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (shift_left_cnt == CNT_W'(1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state machine: outputs
  always_comb begin
    req_stall = 1'b1;
    cell_cmd  = CELL_HOLD;
    rsp_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_EVAL: begin
      end
      S_APPLY: begin
        if (op_q == OP_INSERT) begin
          if (any_match) begin
            cell_cmd = CELL_REPLACE;
          end else if (!full) begin
            cell_cmd = CELL_INSERT;
          end
        end
      end
      S_SHIFT: begin
        cell_cmd = CELL_SHIFT_DOWN;
      end
      S_FINISH: begin
        rsp_load = !rsp_valid || !rsp_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      shift_left_cnt <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_APPLY) begin
        cnt            <= cnt_next;
        shift_left_cnt <= drop_count;
      end else if (state == S_SHIFT) begin
        shift_left_cnt <= shift_left_cnt - CNT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q         <= op_t'(op);
      key_time_q   <= key_time;
      key_value_q  <= key_value;
      keep_q       <= keep_count;
      range_end_q  <= range_end;
      read_index_q <= read_index;
    end
    if (state == S_APPLY) begin
      res_status <= res_status_next;
      res_valid  <= (op_q == OP_READ) && rd_hit;
      res_time   <= ((op_q == OP_READ) && rd_hit) ? rd_time : '0;
      res_value  <= ((op_q == OP_READ) && rd_hit) ? rd_value : '0;
    end
    if (rsp_load) begin
      status      <= res_status;
      fill_level  <= FILL_W'(cnt);
      entry_valid <= res_valid;
      entry_time  <= res_time;
      entry_value <= res_value;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("fill level above table depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && op_q == OP_INSERT && !any_match && !full)
      |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> shift_left_cnt != '0)
    else $error("shift phase with nothing left to drop");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && entry_valid) |-> status == STATUS_DONE)
    else $error("entry data on a response that is not a read");
`endif

endmodule

// File: test/tb_time_keyed_sorted_history_table.sv
module tb_time_keyed_sorted_history_table;
  import tksht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct {
    op_t                      op;
    logic [TIME_W-1:0]        key_time;
    logic signed [VALUE_W-1:0] key_value;
    logic [FILL_W-1:0]        keep_count;
    logic [TIME_W-1:0]        range_end;
    logic [INDEX_W-1:0]       read_index;
  } table_req_t;

  typedef struct {
    status_t                  status;
    logic [FILL_W-1:0]        fill_level;
    logic                     entry_valid;
    logic [TIME_W-1:0]        entry_time;
    logic signed [VALUE_W-1:0] entry_value;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [OP_W-1:0] op = '0;
  logic [TIME_W-1:0] key_time = '0;
  logic signed [VALUE_W-1:0] key_value = '0;
  logic [FILL_W-1:0] keep_count = '0;
  logic [TIME_W-1:0] range_end = '0;
  logic [INDEX_W-1:0] read_index = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0] fill_level;
  logic entry_valid;
  logic [TIME_W-1:0] entry_time;
  logic signed [VALUE_W-1:0] entry_value;

  // shadow copy of the table
  logic [TIME_W-1:0] hist_time [TABLE_SLOTS];
  logic signed [VALUE_W-1:0] hist_value [TABLE_SLOTS];
  int occupied = 0;

  table_req_t send_q[$];
  table_rsp_t due_rsp[$];
  table_req_t on_wire;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  time_keyed_sorted_history_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .key_time    (key_time),
    .key_value   (key_value),
    .keep_count  (keep_count),
    .range_end   (range_end),
    .read_index  (read_index),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .fill_level  (fill_level),
    .entry_valid (entry_valid),
    .entry_time  (entry_time),
    .entry_value (entry_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // first slot whose time is >= t, or > t when strict
  function automatic int find_slot(input logic [TIME_W-1:0] t, input bit strict);
    int lo;
    lo = 0;
    while (lo < occupied && (strict ? (hist_time[lo] <= t) : (hist_time[lo] < t))) lo++;
    return lo;
  endfunction

  task automatic keep_slots(input int first, input int last);
    int n;
    n = (last > first) ? last - first : 0;
    for (int i = 0; i < n; i++) begin
      hist_time[i] = hist_time[first + i];
      hist_value[i] = hist_value[first + i];
    end
    occupied = n;
  endtask

  task automatic apply_history_op(input table_req_t r);
    table_rsp_t a;
    int pos;
    a.status = STATUS_DONE;
    a.entry_valid = 1'b0;
    a.entry_time = '0;
    a.entry_value = '0;
    case (r.op)
      OP_INSERT: begin
        pos = find_slot(r.key_time, 1'b0);
        if (pos < occupied && hist_time[pos] == r.key_time) begin
          hist_value[pos] = r.key_value;
          a.status = STATUS_REPLACED;
        end else if (occupied >= TABLE_SLOTS) begin
          a.status = STATUS_DROPPED;
        end else begin
          for (int i = occupied; i > pos; i--) begin
            hist_time[i] = hist_time[i - 1];
            hist_value[i] = hist_value[i - 1];
          end
          hist_time[pos] = r.key_time;
          hist_value[pos] = r.key_value;
          occupied++;
          a.status = STATUS_INSERTED;
        end
      end
      OP_KEEP_NEWEST: begin
        if (r.keep_count < occupied) keep_slots(occupied - r.keep_count, occupied);
      end
      OP_KEEP_RANGE: begin
        if (r.key_time > r.range_end) occupied = 0;
        else keep_slots(find_slot(r.key_time, 1'b0), find_slot(r.range_end, 1'b1));
      end
      default: begin
        if (r.read_index < occupied) begin
          a.entry_valid = 1'b1;
          a.entry_time = hist_time[r.read_index];
          a.entry_value = hist_value[r.read_index];
        end
      end
    endcase
    a.fill_level = occupied[FILL_W-1:0];
    due_rsp.push_back(a);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  function automatic table_req_t make_req(input op_t o, input logic [TIME_W-1:0] t,
                                          input logic signed [VALUE_W-1:0] v,
                                          input logic [FILL_W-1:0] k,
                                          input logic [TIME_W-1:0] e,
                                          input logic [INDEX_W-1:0] idx);
    table_req_t r;
    r.op = o;
    r.key_time = t;
    r.key_value = v;
    r.keep_count = k;
    r.range_end = e;
    r.read_index = idx;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly a small pool so that times collide, now and then full width or an edge value
  function automatic logic [TIME_W-1:0] pick_time();
    logic [63:0] w;
    w = rand64();
    case ($urandom_range(9))
      0: return w[TIME_W-1:0];
      1: begin
        case ($urandom_range(3))
          0: return '0;
          1: return TIME_MAX;
          2: return TIME_MAX - 1;
          default: return 1;
        endcase
      end
      default: return TIME_W'($urandom_range(400));
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return -1;
      default: return rand64();
    endcase
  endfunction

  function automatic table_req_t noise_req();
    logic [63:0] t;
    logic [63:0] e;
    t = rand64();
    e = rand64();
    return make_req(op_t'($urandom_range(3)), t[TIME_W-1:0], rand64(),
                    FILL_W'($urandom_range(TABLE_SLOTS)), e[TIME_W-1:0],
                    INDEX_W'($urandom_range(63)));
  endfunction

  function automatic table_req_t single_req();
    table_req_t r;
    logic [TIME_W-1:0] lo;
    int span;
    int pick;
    r = noise_req();
    pick = $urandom_range(99);
    if (pick < 50) begin
      r.op = OP_INSERT;
      r.key_time = pick_time();
      r.key_value = pick_value();
    end else if (pick < 80) begin
      r.op = OP_READ;
    end else if (pick < 90) begin
      r.op = OP_KEEP_NEWEST;
      r.keep_count = ($urandom_range(4) == 0) ? FILL_W'($urandom_range(TABLE_SLOTS))
                                              : FILL_W'($urandom_range(TABLE_SLOTS, 30));
    end else begin
      r.op = OP_KEEP_RANGE;
      lo = pick_time();
      span = $urandom_range(400);
      r.key_time = lo;
      r.range_end = (lo > TIME_MAX - span) ? TIME_MAX : lo + span;
      // an inverted range now and then
      if ($urandom_range(5) == 0) begin
        r.key_time = r.range_end;
        r.range_end = lo;
      end
    end
    return r;
  endfunction

  task automatic queue_directed_items();
    send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, 0));
    send_q.push_back(make_req(OP_KEEP_NEWEST, 0, 0, 0, 0, 0));
    send_q.push_back(make_req(OP_KEEP_RANGE, 5, 0, 0, 2, 0));
    send_q.push_back(make_req(OP_INSERT, 100, VALUE_MAX, 0, 0, 0));
    send_q.push_back(make_req(OP_INSERT, 0, VALUE_MIN, 0, 0, 0));
    send_q.push_back(make_req(OP_INSERT, TIME_MAX, -1, 0, 0, 0));
    send_q.push_back(make_req(OP_INSERT, 50, 0, 0, 0, 0));
    send_q.push_back(make_req(OP_INSERT, 100, 12345, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, INDEX_W'(i)));
    send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, 63));
    send_q.push_back(make_req(OP_KEEP_NEWEST, 0, 0, TABLE_SLOTS, 0, 0));
    send_q.push_back(make_req(OP_KEEP_NEWEST, 0, 0, 4, 0, 0));
    send_q.push_back(make_req(OP_KEEP_NEWEST, 0, 0, 3, 0, 0));
    send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, 0));
    send_q.push_back(make_req(OP_KEEP_RANGE, 0, 0, 0, TIME_MAX, 0));
    send_q.push_back(make_req(OP_KEEP_RANGE, 60, 0, 0, 100, 0));
    send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, 0));
    send_q.push_back(make_req(OP_KEEP_RANGE, 200, 0, 0, 100, 0));
    send_q.push_back(make_req(OP_INSERT, 1, 7, 0, 0, 0));
    send_q.push_back(make_req(OP_INSERT, 3, -7, 0, 0, 0));
    send_q.push_back(make_req(OP_KEEP_RANGE, 1, 0, 0, 1, 0));
    send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, 0));
  endtask

  task automatic queue_mixed_items(input int n);
    int made;
    int burst;
    logic [63:0] e;
    made = 0;
    while (made < n) begin
      case ($urandom_range(9))
        0, 1: begin
          // enough inserts to fill the table and then run into it
          burst = $urandom_range(100, 70);
          for (int i = 0; i < burst; i++) begin
            e = rand64();
            send_q.push_back(make_req(OP_INSERT, pick_time(), pick_value(),
                                      FILL_W'($urandom_range(TABLE_SLOTS)),
                                      e[TIME_W-1:0], INDEX_W'($urandom_range(63))));
          end
          made += burst;
        end
        2: begin
          for (int i = 0; i < 64; i += $urandom_range(3, 1)) begin
            send_q.push_back(make_req(OP_READ, 0, 0, 0, 0, INDEX_W'(i)));
            made++;
          end
        end
        3: begin
          send_q.push_back(noise_req());
          made++;
        end
        default: begin
          send_q.push_back(single_req());
          made++;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || req_valid || due_rsp.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_req
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) apply_history_op(on_wire);
      if (!req_valid || !req_stall) begin
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = send_q.pop_front();
          req_valid <= 1'b1;
          op <= on_wire.op;
          key_time <= on_wire.key_time;
          key_value <= on_wire.key_value;
          keep_count <= on_wire.keep_count;
          range_end <= on_wire.range_end;
          read_index <= on_wire.read_index;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_rsp
    table_rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          $error("response item with no item outstanding");
          mismatches++;
        end else begin
          want = due_rsp.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("fill_level", 64'(want.fill_level), 64'(fill_level));
          check_field("entry_valid", 64'(want.entry_valid), 64'(entry_valid));
          check_field("entry_time", 64'(want.entry_time), 64'(entry_time));
          check_field("entry_value", want.entry_value, entry_value);
        end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_directed_items();
    wait_drained();
    // each phase drains fully before the next one starts
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    queue_mixed_items(457);
    wait_drained();
    send_idle_pct = 84;
    rsp_stall_pct = 0;
    queue_mixed_items(457);
    wait_drained();
    send_idle_pct = 0;
    rsp_stall_pct = 84;
    queue_mixed_items(457);
    wait_drained();
    send_idle_pct = 34;
    rsp_stall_pct = 34;
    queue_mixed_items(457);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && due_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tksht_pkg.sv
rtl/core/tksht_cell.sv
rtl/core/time_keyed_sorted_history_table.sv
test/tb_time_keyed_sorted_history_table.sv
